/* rtl/poida_pkg.sv */
// Package for the packed object id allocator.
// Holds sizes, operation and status codes, register indexes and the
// controller command struct. Depends on nothing.
package poida_pkg;

  // Storage sizes.
  localparam int NUM_TYPES    = 256;
  localparam int NUM_SWITCHES = 256;
  localparam int INDEX_BITS   = 32;

  localparam int TYPE_AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int SW_AW   = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int CTR_W   = INDEX_BITS + 1;

  // Fixed field widths of the id layout and the ports.
  localparam int ID_W     = 64;
  localparam int RID_W    = 56;
  localparam int FIELD_W  = 8;
  localparam int IX_W     = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;
  localparam int CFG_IX_W = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC       = 3'd0,
    OP_REG_SWITCH  = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_WARM_BOOT   = 3'd3,
    OP_QUERY       = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK             = 3'd0,
    ST_BAD_TYPE       = 3'd1,
    ST_SWITCH_TYPE    = 3'd2,
    ST_NOT_SWITCH     = 3'd3,
    ST_EXHAUSTED      = 3'd4,
    ST_NOT_REGISTERED = 3'd5
  } st_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_CONTEXT     = 2'd0,
    CFG_TYPE_LIMIT  = 2'd1,
    CFG_SWITCH_TYPE = 2'd2
  } cfg_idx_t;

  // Configuration reset values.
  localparam logic [FIELD_W-1:0] RST_CONTEXT     = 8'd0;
  localparam logic [FIELD_W-1:0] RST_TYPE_LIMIT  = 8'd254;
  localparam logic [FIELD_W-1:0] RST_SWITCH_TYPE = 8'd33;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch input transaction and read the counter memory
    logic execute;  // update state and load the result register
    logic cfg_wr;   // write a configuration register
  } ctrl_cmd_t;

endpackage

/* rtl/poida_in_if.sv */
// Input channel interface of the object id allocator.
// Depends on poida_pkg.
interface poida_in_if import poida_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [FIELD_W-1:0] object_type;
  logic [ID_W-1:0]    object_id;
  logic [FIELD_W-1:0] switch_index;

  modport source (output valid, output operation, output object_type,
                  output object_id, output switch_index, input ready);
  modport sink (input valid, input operation, input object_type,
                input object_id, input switch_index, output ready);
endinterface

/* rtl/poida_out_if.sv */
// Result channel interface of the object id allocator.
// Depends on poida_pkg.
interface poida_out_if import poida_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RID_W-1:0]   result_id;
  logic [FIELD_W-1:0] result_type;
  logic [ST_W-1:0]    status;

  modport source (output valid, output result_id, output result_type,
                  output status, input ready);
  modport sink (input valid, input result_id, input result_type,
                input status, output ready);
endinterface

/* rtl/poida_cfg_if.sv */
// Configuration write channel interface of the object id allocator.
// Depends on poida_pkg.
interface poida_cfg_if import poida_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_IX_W-1:0] index;
  logic [FIELD_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/packed_object_id_allocator_unit.sv */
// Packed object id allocator, top level.
// A transaction is accepted in S_IDLE and executed in S_EXEC once the result
// register is free; its result is registered. No new one is taken until it is
// executed, as the per-type counter memory is read on accept, written on execute.
// Reset (rst_n low, synchronous): counters read as zero at once through valid
// flops; switch presence, state and config registers reset; no clearing pass.
module packed_object_id_allocator_unit import poida_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  poida_in_if.sink    in_ch,
  poida_out_if.source out_ch,
  poida_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  poida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cmd       (cmd)
  );

  poida_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .operation    (in_ch.operation),
    .object_type  (in_ch.object_type),
    .object_id    (in_ch.object_id),
    .switch_index (in_ch.switch_index),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .result_id    (out_ch.result_id),
    .result_type  (out_ch.result_type),
    .status       (out_ch.status)
  );

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> (!out_valid || out_ch.ready))
    else $error("result register overwritten before it was taken");

  // Execution always presents a result next cycle.
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid)
    else $error("executed transaction produced no result");

  // Execution never coincides with acceptance.
  a_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.execute && cmd.accept))
    else $error("accept and execute in the same cycle");

endmodule

/* rtl/poida_ctrl.sv */
// Controller of the object id allocator: accept/execute state machine
// and result valid flag. Depends on poida_pkg.
module poida_ctrl import poida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      cfg_valid,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.execute = 1'b0;
    cmd.cfg_wr  = cfg_valid;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = slot_free;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/poida_dp.sv */
// Datapath of the object id allocator: configuration registers, counter
// memory with valid bits, switch presence bits and result register.
// Depends on poida_pkg.
module poida_dp import poida_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  input  logic [OP_W-1:0]     operation,
  input  logic [FIELD_W-1:0]  object_type,
  input  logic [ID_W-1:0]     object_id,
  input  logic [FIELD_W-1:0]  switch_index,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]  cfg_data,
  output logic [RID_W-1:0]    result_id,
  output logic [FIELD_W-1:0]  result_type,
  output logic [ST_W-1:0]     status
);

  localparam logic [CTR_W-1:0]   CAP      = CTR_W'(1) << INDEX_BITS;
  localparam logic [IX_W:0]      CAP_WIDE = (IX_W + 1)'(CAP);
  localparam logic [FIELD_W:0]   TYPES_LIM = (FIELD_W + 1)'(NUM_TYPES);
  localparam logic [FIELD_W:0]   SW_LIM    = (FIELD_W + 1)'(NUM_SWITCHES);

  // Configuration registers.
  logic [FIELD_W-1:0] ctx_r, type_limit_r, switch_type_r;

  // Latched input transaction.
  logic [OP_W-1:0]    op_r;
  logic [FIELD_W-1:0] otype_r;
  logic [ID_W-1:0]    oid_r;
  logic [FIELD_W-1:0] sidx_r;
  logic [TYPE_AW-1:0] addr_r;

  // Counter memory, its valid bits and the registered read.
  logic [CTR_W-1:0]     ctr_mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] ctr_vld_r;
  logic [CTR_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  // Switch presence bits.
  logic [NUM_SWITCHES-1:0] sw_present_r;

  // Result register.
  logic [RID_W-1:0]   rid_r, rid_nxt;
  logic [FIELD_W-1:0] rtype_r, rtype_nxt;
  st_t                st_r, st_nxt;

  // Decoded fields and update controls.
  logic [TYPE_AW-1:0] rd_addr;
  logic [FIELD_W-1:0] id_type, id_sw, vt;
  logic               otype_ok, id_type_ok, sw_in_range, sidx_in_range;
  logic               sw_present;
  logic [CTR_W-1:0]   ctr;
  logic [IX_W:0]      ix_wide, next_wide;
  logic               mem_we;
  logic [CTR_W-1:0]   mem_wdata;
  logic               pres_set, pres_clr, clear_all;
  logic [SW_AW-1:0]   pres_idx;

  // Read address: the allocated type, or the type field of the id.
  assign rd_addr = (operation == OP_ALLOC) ? object_type[TYPE_AW-1:0]
                                           : object_id[32 +: TYPE_AW];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r         <= RST_CONTEXT;
      type_limit_r  <= RST_TYPE_LIMIT;
      switch_type_r <= RST_SWITCH_TYPE;
    end else if (cmd.cfg_wr) begin
      unique case (cfg_index)
        CFG_CONTEXT:     ctx_r         <= cfg_data;
        CFG_TYPE_LIMIT:  type_limit_r  <= cfg_data;
        CFG_SWITCH_TYPE: switch_type_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input latch and counter memory read/write.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= operation;
      otype_r   <= object_type;
      oid_r     <= object_id;
      sidx_r    <= switch_index;
      addr_r    <= rd_addr;
      rd_data_r <= ctr_mem[rd_addr];
    end
    if (mem_we) begin
      ctr_mem[addr_r] <= mem_wdata;
    end
  end

  // Valid bits of the counter memory, read along with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_vld_r <= ctr_vld_r[rd_addr];
      end
      if (clear_all) begin
        ctr_vld_r <= '0;
      end else if (mem_we) begin
        ctr_vld_r[addr_r] <= 1'b1;
      end
    end
  end

  // Switch presence bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_present_r <= '0;
    end else if (clear_all) begin
      sw_present_r <= '0;
    end else if (pres_set) begin
      sw_present_r[pres_idx] <= 1'b1;
    end else if (pres_clr) begin
      sw_present_r[pres_idx] <= 1'b0;
    end
  end

  // Field decode of the latched transaction.
  assign id_type       = oid_r[39:32];
  assign id_sw         = oid_r[47:40];
  assign otype_ok      = (otype_r != '0) && (otype_r < type_limit_r) &&
                         ({1'b0, otype_r} < TYPES_LIM);
  assign id_type_ok    = (oid_r != '0) && (id_type != '0) &&
                         (id_type < type_limit_r) && ({1'b0, id_type} < TYPES_LIM);
  assign vt            = id_type_ok ? id_type : '0;
  assign sw_in_range   = {1'b0, id_sw} < SW_LIM;
  assign sidx_in_range = {1'b0, sidx_r} < SW_LIM;
  assign sw_present    = sw_in_range && sw_present_r[id_sw[SW_AW-1:0]];
  assign ctr           = rd_vld_r ? rd_data_r : '0;
  assign ix_wide       = {1'b0, oid_r[IX_W-1:0]};
  assign next_wide     = (ix_wide >= CAP_WIDE) ? CAP_WIDE : (ix_wide + 1'b1);

  // Operation execution.
  always_comb begin
    rid_nxt   = '0;
    rtype_nxt = '0;
    st_nxt    = ST_OK;
    mem_we    = 1'b0;
    mem_wdata = ctr + 1'b1;
    pres_set  = 1'b0;
    pres_clr  = 1'b0;
    pres_idx  = id_sw[SW_AW-1:0];
    clear_all = 1'b0;
    unique case (op_r)
      OP_ALLOC: begin
        rtype_nxt = vt;
        if (!otype_ok) begin
          st_nxt = ST_BAD_TYPE;
        end else if (otype_r == switch_type_r) begin
          st_nxt = ST_SWITCH_TYPE;
        end else if ((vt == '0) || (vt != switch_type_r)) begin
          st_nxt = ST_NOT_SWITCH;
        end else if (ctr >= CAP) begin
          st_nxt = ST_EXHAUSTED;
        end else begin
          mem_we  = cmd.execute;
          rid_nxt = {ctx_r, id_sw, otype_r, IX_W'(ctr[INDEX_BITS-1:0])};
        end
      end
      OP_REG_SWITCH: begin
        pres_idx = sidx_r[SW_AW-1:0];
        if (!sidx_in_range) begin
          st_nxt = ST_NOT_REGISTERED;
        end else begin
          pres_set = cmd.execute;
          rid_nxt  = {ctx_r, sidx_r, switch_type_r, IX_W'(sidx_r)};
        end
      end
      OP_RELEASE: begin
        rtype_nxt = vt;
        if ((vt != '0) && (vt == switch_type_r)) begin
          if (sw_present) begin
            pres_clr = cmd.execute;
          end else begin
            st_nxt = ST_NOT_REGISTERED;
          end
        end
      end
      OP_WARM_BOOT: begin
        rtype_nxt = vt;
        mem_wdata = CTR_W'(next_wide);
        if (vt == '0) begin
          st_nxt = ST_BAD_TYPE;
        end else begin
          pres_set = cmd.execute && (vt == switch_type_r) && sw_in_range;
          if (ix_wide >= CAP_WIDE) begin
            st_nxt = ST_EXHAUSTED;
          end
          mem_we = cmd.execute && ((IX_W + 1)'(ctr) <= ix_wide);
        end
      end
      OP_QUERY: begin
        rtype_nxt = vt;
        if (oid_r == '0) begin
          st_nxt = ST_OK;
        end else if (vt == '0) begin
          st_nxt = ST_BAD_TYPE;
        end else if (vt == switch_type_r) begin
          rid_nxt = oid_r[RID_W-1:0];
        end else begin
          rid_nxt = {oid_r[55:48], id_sw, switch_type_r, IX_W'(id_sw)};
        end
      end
      OP_CLEAR: begin
        clear_all = cmd.execute;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rid_r   <= rid_nxt;
      rtype_r <= rtype_nxt;
      st_r    <= st_nxt;
    end
  end

  assign result_id   = rid_r;
  assign result_type = rtype_r;
  assign status      = st_r;

endmodule
